// ===== rtl/core/aging_priority_event_queue_macros.svh =====
// Assertion helpers for the aging priority event queue.
`ifndef AGING_PRIORITY_EVENT_QUEUE_MACROS_SVH
`define AGING_PRIORITY_EVENT_QUEUE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define APEQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("apeq check failed");
`define APEQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("apeq check failed");
`else
`define APEQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define APEQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/apeq_pkg.sv =====
package apeq_pkg;

    localparam int unsigned KEY_W   = 5;
    localparam int unsigned LVL_W   = 2;
    localparam int unsigned TAG_W   = 32;
    localparam int unsigned SIZE_W  = 16;
    localparam int unsigned LIFE_W  = 15;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned CIDX_W  = 1;

    localparam logic [CIDX_W-1:0] CFG_LIFE_TIME = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_REG_KEYS  = 1'b1;

    localparam logic REQ_PUBLISH = 1'b0;
    localparam logic REQ_POP     = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef struct packed {
        logic              req_type;
        logic [KEY_W-1:0]  event_key;
        logic [LVL_W-1:0]  priority_req;
        logic [TAG_W-1:0]  payload_tag;
        logic [SIZE_W-1:0] payload_size;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [KEY_W-1:0]  out_key;
        logic [LVL_W-1:0]  out_level;
        logic [TAG_W-1:0]  out_payload_tag;
        logic [SIZE_W-1:0] out_payload_size;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUB,
        S_SCAN,
        S_POP,
        S_AGE_CHK,
        S_AGE_MOVE,
        S_DONE
    } t_state;

endpackage

// ===== rtl/core/aging_priority_event_queue.sv =====
// Channel   | handshake             | payload
// ----------+-----------------------+--------------------------
// input     | i_in_valid/o_in_stall | i_in_item  (t_in_item)
// output    | o_out_valid/i_out_stall | o_out_item (t_out_item)
// config    | i_cfg_we              | i_cfg_index, i_cfg_data
//
// One transfer at a time. Publish: accept, check/append, hand-off.
// Pop: accept, a scan of each level up to the first non-empty one, the
// dequeue, then per level 1..NUM_LEVELS-1 a final age check plus a move
// and a recheck per promoted head, then the hand-off. An empty pop scans
// every level, then hands off. The levels share one stamp subtract/compare
// unit.
// Reset (synchronous, i_rst_n low) builds the free chain.
// The result register holds while i_out_stall is high; a new item is taken
// once the result is handed off.
`include "aging_priority_event_queue_macros.svh"
module aging_priority_event_queue #(
    parameter int unsigned NUM_LEVELS = 4,
    parameter int unsigned POOL_DEPTH = 16,
    parameter int unsigned NUM_KEYS   = 32,
    parameter int unsigned STAMP_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  apeq_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output apeq_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_we,
    input  logic [apeq_pkg::CIDX_W-1:0]         i_cfg_index,
    input  logic [apeq_pkg::CFG_W-1:0]          i_cfg_data
);
    import apeq_pkg::*;

    localparam int unsigned SW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int unsigned CW = $clog2(POOL_DEPTH + 1);
    localparam int unsigned LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

    // slot storage (memory, no reset; the r_next chain is reset)
    logic [KEY_W-1:0]      m_key  [POOL_DEPTH];
    logic [STAMP_BITS-1:0] m_stamp[POOL_DEPTH];
    logic [TAG_W-1:0]      m_tag  [POOL_DEPTH];
    logic [SIZE_W-1:0]     m_size [POOL_DEPTH];
    logic [SW-1:0]         r_next [POOL_DEPTH];

    logic [SW-1:0]         r_head [NUM_LEVELS];
    logic [SW-1:0]         r_tail [NUM_LEVELS];
    logic [CW-1:0]         r_count[NUM_LEVELS];
    logic [SW-1:0]         r_free;
    logic [STAMP_BITS-1:0] r_stamp;
    logic [CW-1:0]         r_total;
    logic [LIFE_W-1:0]     r_life;
    logic [CFG_W-1:0]      r_regkeys;

    t_state    r_state, n_state;
    t_in_item  r_req;
    t_out_item r_out;
    logic      r_out_valid;
    logic [LW-1:0] r_lvl;

    // shared age unit: head of r_lvl
    logic [STAMP_BITS-1:0] w_age;
    logic                  w_old;
    logic [SW-1:0]         w_hs;
    logic                  w_keyok;
    logic                  w_lvl_last;

    assign w_hs   = r_head[r_lvl];
    assign w_age  = r_stamp - m_stamp[w_hs];
    assign w_old  = 32'(w_age) >= 32'(r_life);
    assign w_lvl_last = (r_lvl == LW'(NUM_LEVELS - 1));
    assign w_keyok = (32'(r_req.event_key) < NUM_KEYS) && (r_req.event_key < 6'd32)
                     && r_regkeys[r_req.event_key]
                     && (32'(r_req.priority_req) < NUM_LEVELS);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_in_valid) n_state = (i_in_item.req_type == REQ_POP) ? S_SCAN : S_PUB;
            S_PUB:      n_state = S_DONE;
            S_SCAN: begin
                if (r_count[r_lvl] != '0) n_state = S_POP;
                else if (w_lvl_last) n_state = S_DONE;
            end
            S_POP:      n_state = (NUM_LEVELS > 1) ? S_AGE_CHK : S_DONE;
            S_AGE_CHK: begin
                if (r_count[r_lvl] != '0 && w_old) n_state = S_AGE_MOVE;
                else if (w_lvl_last) n_state = S_DONE;
            end
            S_AGE_MOVE: n_state = S_AGE_CHK;
            S_DONE:     if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = (r_state != S_IDLE);
        o_out_valid = r_out_valid;
        o_out_item  = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_free      <= '0;
            r_stamp     <= '0;
            r_total     <= '0;
            r_life      <= LIFE_W'(8);
            r_regkeys   <= '0;
            r_lvl       <= '0;
            for (int i = 0; i < POOL_DEPTH; i++) r_next[i] <= SW'((i + 1) % POOL_DEPTH);
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_head[l]  <= '0;
                r_tail[l]  <= '0;
                r_count[l] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_LIFE_TIME: r_life    <= i_cfg_data[LIFE_W-1:0];
                    CFG_REG_KEYS:  r_regkeys <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    r_req <= i_in_item;
                    r_lvl <= '0;
                end
                S_PUB: begin
                    r_out.out_key          <= '0;
                    r_out.out_level        <= '0;
                    r_out.out_payload_tag  <= '0;
                    r_out.out_payload_size <= '0;
                    r_out_valid <= 1'b1;
                    if (!w_keyok) r_out.status <= ST_INVALID;
                    else if (r_total >= CW'(POOL_DEPTH)) r_out.status <= ST_FULL;
                    else begin
                        r_out.status <= ST_OK;
                        r_free <= r_next[r_free];
                        m_key[r_free]   <= r_req.event_key;
                        m_stamp[r_free] <= r_stamp;
                        m_tag[r_free]   <= r_req.payload_tag;
                        m_size[r_free]  <= r_req.payload_size;
                        if (r_count[LW'(r_req.priority_req)] == '0)
                            r_head[LW'(r_req.priority_req)] <= r_free;
                        else
                            r_next[r_tail[LW'(r_req.priority_req)]] <= r_free;
                        r_tail[LW'(r_req.priority_req)]  <= r_free;
                        r_count[LW'(r_req.priority_req)] <= r_count[LW'(r_req.priority_req)] + 1'b1;
                        r_total <= r_total + 1'b1;
                    end
                end
                S_SCAN: begin
                    if (r_count[r_lvl] == '0) begin
                        if (w_lvl_last) begin
                            r_out.status           <= ST_EMPTY;
                            r_out.out_key          <= '0;
                            r_out.out_level        <= '0;
                            r_out.out_payload_tag  <= '0;
                            r_out.out_payload_size <= '0;
                            r_out_valid <= 1'b1;
                        end else r_lvl <= r_lvl + 1'b1;
                    end
                end
                S_POP: begin
                    r_out.status           <= ST_OK;
                    r_out.out_key          <= m_key[w_hs];
                    r_out.out_level        <= LVL_W'(r_lvl);
                    r_out.out_payload_tag  <= m_tag[w_hs];
                    r_out.out_payload_size <= m_size[w_hs];
                    r_out_valid <= (NUM_LEVELS <= 1);
                    r_head[r_lvl]  <= r_next[w_hs];
                    r_count[r_lvl] <= r_count[r_lvl] - 1'b1;
                    r_next[w_hs]   <= r_free;
                    r_free         <= w_hs;
                    r_total        <= r_total - 1'b1;
                    r_stamp        <= r_stamp + 1'b1;
                    r_lvl          <= LW'(1);
                end
                S_AGE_CHK: begin
                    if (!(r_count[r_lvl] != '0 && w_old)) begin
                        if (w_lvl_last) r_out_valid <= 1'b1;
                        else r_lvl <= r_lvl + 1'b1;
                    end
                end
                S_AGE_MOVE: begin
                    r_head[r_lvl]  <= r_next[w_hs];
                    r_count[r_lvl] <= r_count[r_lvl] - 1'b1;
                    m_stamp[w_hs]  <= r_stamp;
                    if (r_count[r_lvl - 1'b1] == '0) r_head[r_lvl - 1'b1] <= w_hs;
                    else r_next[r_tail[r_lvl - 1'b1]] <= w_hs;
                    r_tail[r_lvl - 1'b1]  <= w_hs;
                    r_count[r_lvl - 1'b1] <= r_count[r_lvl - 1'b1] + 1'b1;
                end
                S_DONE: ;
                default: ;
            endcase
        end
    end

    `APEQ_ASSERT_IMP(a_busy_stall, i_clk, i_rst_n, r_state != S_IDLE, o_in_stall)
    `APEQ_ASSERT_IMP(a_total_max, i_clk, i_rst_n, 1'b1, r_total <= CW'(POOL_DEPTH))
    `APEQ_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state != S_IDLE)
    `APEQ_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import apeq_pkg::*;

    localparam int NLVL = 4;
    localparam int NSLOT = 16;
    localparam int CYCLE_LIMIT = 5000000;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_in_valid = 1'b0;
    logic            o_in_stall;
    t_in_item        i_in_item = '0;
    logic            o_out_valid;
    logic            i_out_stall = 1'b0;
    t_out_item       o_out_item;
    logic            i_cfg_we = 1'b0;
    logic [CIDX_W-1:0] i_cfg_index = CFG_LIFE_TIME;
    logic [CFG_W-1:0]  i_cfg_data = '0;

    aging_priority_event_queue dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---- shadow of the event pool ----
    logic [KEY_W-1:0]  pool_key   [NSLOT];
    logic [15:0]       pool_stamp [NSLOT];
    logic [TAG_W-1:0]  pool_tag   [NSLOT];
    logic [SIZE_W-1:0] pool_size  [NSLOT];
    logic [3:0]        pool_next  [NSLOT];
    logic [3:0]        lvl_head   [NLVL];
    logic [3:0]        lvl_tail   [NLVL];
    int                lvl_cnt    [NLVL];
    logic [3:0]        free_slot;
    logic [15:0]       cur_stamp;
    int                queued;
    logic [LIFE_W-1:0] life_cfg;
    logic [31:0]       key_mask;

    t_out_item   pending_results[$];
    int          mismatches = 0;
    int          cycles = 0;

    // sender pacing and receiver stall control
    int  burst_left = 0;
    bit  sender_steady = 0;
    bit  sink_steady = 0;
    int  hold_request = 0;
    int  hold_left = 0;

    function automatic logic [3:0] dequeue_head(int l);
        logic [3:0] s;
        s = lvl_head[l];
        lvl_head[l] = pool_next[s];
        lvl_cnt[l]--;
        return s;
    endfunction

    function automatic void enqueue_tail(int l, logic [3:0] s);
        if (lvl_cnt[l] == 0) begin
            lvl_head[l] = s;
        end else begin
            pool_next[lvl_tail[l]] = s;
        end
        lvl_tail[l] = s;
        lvl_cnt[l]++;
    endfunction

    function automatic void reset_pool();
        for (int i = 0; i < NSLOT; i++) pool_next[i] = 4'((i + 1) % NSLOT);
        for (int l = 0; l < NLVL; l++) begin
            lvl_head[l] = '0;
            lvl_tail[l] = '0;
            lvl_cnt[l] = 0;
        end
        free_slot = '0;
        cur_stamp = '0;
        queued = 0;
        life_cfg = 15'd8;
        key_mask = '0;
    endfunction

    // Next result for one accepted request; updates the shadow pool.
    function automatic t_out_item queue_response(t_in_item it);
        t_out_item r;
        logic [3:0] s;
        logic [15:0] age;
        int l;
        r = '0;
        if (it.req_type == REQ_PUBLISH) begin
            if (!key_mask[it.event_key]) begin
                r.status = ST_INVALID;
            end else if (queued >= NSLOT) begin
                r.status = ST_FULL;
            end else begin
                s = free_slot;
                free_slot = pool_next[s];
                pool_key[s] = it.event_key;
                pool_stamp[s] = cur_stamp;
                pool_tag[s] = it.payload_tag;
                pool_size[s] = it.payload_size;
                enqueue_tail(int'(it.priority_req), s);
                queued++;
                r.status = ST_OK;
            end
            return r;
        end
        for (l = 0; l < NLVL; l++) if (lvl_cnt[l] != 0) break;
        if (l >= NLVL) begin
            r.status = ST_EMPTY;
            return r;
        end
        s = dequeue_head(l);
        r.status = ST_OK;
        r.out_key = pool_key[s];
        r.out_level = LVL_W'(l);
        r.out_payload_tag = pool_tag[s];
        r.out_payload_size = pool_size[s];
        pool_next[s] = free_slot;
        free_slot = s;
        queued--;
        cur_stamp = cur_stamp + 16'd1;
        // aging: promote stale heads one level up, lowest levels last
        for (int a = 1; a < NLVL; a++) begin
            while (lvl_cnt[a] != 0) begin
                age = cur_stamp - pool_stamp[lvl_head[a]];
                if (age < {1'b0, life_cfg}) break;
                s = dequeue_head(a);
                pool_stamp[s] = cur_stamp;
                enqueue_tail(a - 1, s);
            end
        end
        return r;
    endfunction

    // ---- sender: one transfer, with bursts and gaps ----
    task automatic send_item(t_in_item it);
        int gap;
        if (!sender_steady && burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(queue_response(it));
        if (burst_left > 0) burst_left--;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Registers change only with the block idle.
    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
        drain();
        repeat (16) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_LIFE_TIME) life_cfg = val[LIFE_W-1:0];
        else key_mask = val;
    endtask

    function automatic t_in_item publish(logic [4:0] k, logic [1:0] p,
                                         logic [31:0] t, logic [15:0] sz);
        t_in_item it;
        it.req_type = REQ_PUBLISH;
        it.event_key = k;
        it.priority_req = p;
        it.payload_tag = t;
        it.payload_size = sz;
        return it;
    endfunction

    function automatic t_in_item pop_req();
        t_in_item it;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        it = raw[$bits(t_in_item)-1:0];
        it.req_type = REQ_POP;
        return it;
    endfunction

    // ---- receiver stall pattern; long holds are counted here ----
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (sink_steady || (cycles % 2000) < 300) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    // ---- result checker ----
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: %h", o_out_item);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_item.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_item.status);
                    mismatches++;
                end
                if (o_out_item.out_key !== want.out_key) begin
                    $error("out_key: expected %0d, got %0d", want.out_key, o_out_item.out_key);
                    mismatches++;
                end
                if (o_out_item.out_level !== want.out_level) begin
                    $error("out_level: expected %0d, got %0d",
                           want.out_level, o_out_item.out_level);
                    mismatches++;
                end
                if (o_out_item.out_payload_tag !== want.out_payload_tag) begin
                    $error("out_payload_tag: expected %h, got %h",
                           want.out_payload_tag, o_out_item.out_payload_tag);
                    mismatches++;
                end
                if (o_out_item.out_payload_size !== want.out_payload_size) begin
                    $error("out_payload_size: expected %h, got %h",
                           want.out_payload_size, o_out_item.out_payload_size);
                    mismatches++;
                end
            end
        end
    end

    // ---- watchdog ----
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Rejections, empty pop, full pool, extremes of every field.
    task automatic test_directed();
        send_item(publish(5'd3, 2'd0, 32'h1, 16'h1));      // nothing registered yet
        send_item(pop_req());                              // empty queue
        write_reg(CFG_REG_KEYS, 32'h7FFF_FFFF);            // key 31 stays unregistered
        write_reg(CFG_LIFE_TIME, 32'd1);
        send_item(publish(5'd0, 2'd3, 32'hFFFF_FFFF, 16'hFFFF));
        send_item(publish(5'd30, 2'd0, 32'h0, 16'h0));
        send_item(publish(5'd31, 2'd1, 32'hA5A5_5A5A, 16'h1234));
        for (int i = 0; i < 14; i++)
            send_item(publish(5'(i), 2'(i), $urandom, 16'($urandom)));
        send_item(publish(5'd5, 2'd2, 32'h5555_AAAA, 16'hAAAA)); // pool full
        send_item(publish(5'd31, 2'd2, 32'h1, 16'h1));     // invalid beats full
        for (int i = 0; i < 4; i++) send_item(pop_req());
        // zero lifetime: every waiting head moves up on each pop
        write_reg(CFG_LIFE_TIME, 32'd0);
        while (queued > 0) send_item(pop_req());
        send_item(pop_req());
    endtask

    // Random mixes over several register settings, with pressure phases.
    task automatic test_random();
        logic [31:0] masks [4];
        logic [14:0] lives [4];
        t_in_item it;
        logic [63:0] raw;
        masks = '{32'hFFFF_FFFF, 32'h0F0F_3C3C, $urandom, 32'h8000_0001};
        lives = '{15'd32767, 15'd3, 15'($urandom_range(1, 24)), 15'd0};
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_LIFE_TIME, 32'(lives[ph]));
            write_reg(CFG_REG_KEYS, masks[ph]);
            for (int n = 0; n < 360; n++) begin
                if (ph == 1 && n == 100) hold_request = 400;   // block backs up
                if (ph == 2 && n == 200) drain();              // sender waits it out
                // favor pops when the pool runs full, publishes when it is low
                if ($urandom_range(0, 15) < (queued + 2) / 2) begin
                    it = pop_req();
                end else begin
                    raw = {$urandom, $urandom};
                    it = raw[$bits(t_in_item)-1:0];
                    it.req_type = REQ_PUBLISH;
                    if ($urandom_range(0, 9) != 0 && masks[ph] != 0)
                        while (!masks[ph][it.event_key]) it.event_key = 5'($urandom);
                end
                send_item(it);
            end
        end
    endtask

    // Long wait: one old event sits at the lowest level under a long
    // lifetime while back-to-back traffic passes through level 0.
    task automatic test_long_wait();
        write_reg(CFG_LIFE_TIME, 32'd32767);
        write_reg(CFG_REG_KEYS, 32'hFFFF_FFFF);
        while (queued > 0) send_item(pop_req());
        sender_steady = 1;
        sink_steady = 1;
        send_item(publish(5'd17, 2'd3, 32'hDEAD_BEEF, 16'hBEEF));
        for (int n = 0; n < 60; n++) begin
            send_item(publish(5'($urandom), 2'd0, $urandom, 16'($urandom)));
            send_item(pop_req());
        end
        sender_steady = 0;
        sink_steady = 0;
        while (queued > 0) send_item(pop_req());
    endtask

    initial begin
        reset_pool();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_long_wait();
        drain();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
